>>> rtl/fnss_pkg.sv
// ----------------------------------------------------------------------------
// fnss_pkg
// Types, constants and helpers shared by the node state supervisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fnss_pkg;

  localparam int DEFAULT_MAX_NODES = 32;

  localparam int NODE_W   = 5;
  localparam int STATE_W  = 5;
  localparam int DELAY_W  = 8;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [STATE_W-1:0] ST_NONE   = 5'h00;
  localparam logic [STATE_W-1:0] ST_INIT   = 5'h01;
  localparam logic [STATE_W-1:0] ST_PREOP  = 5'h02;
  localparam logic [STATE_W-1:0] ST_SAFEOP = 5'h04;
  localparam logic [STATE_W-1:0] ST_OP     = 5'h08;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREOP_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAFEOP_LIMIT   = 2'd2;

  localparam logic [DELAY_W-1:0] RECOVERY_DELAY_RST = 8'd50;
  localparam logic [COUNT_W-1:0] PREOP_LIMIT_RST    = 16'd10;
  localparam logic [COUNT_W-1:0] SAFEOP_LIMIT_RST   = 16'd5;

  typedef enum logic [0:0] {
    S_IDLE,
    S_UPDATE
  } fnss_state_t;

  typedef struct packed {
    logic               lost;
    logic [DELAY_W-1:0] dly;
    logic [STATE_W-1:0] prev;
    logic [COUNT_W-1:0] err;
    logic [COUNT_W-1:0] rec;
  } fnss_entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } fnss_cmd_t;

  typedef struct packed {
    logic out_free;
  } fnss_sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fnss_ram.sv
// ----------------------------------------------------------------------------
// fnss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/fnss_ctrl.sv
// ----------------------------------------------------------------------------
// fnss_ctrl
// Sequencer: accepts a poll result, then commits the table update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire fnss_pkg::fnss_sts_t sts,
  output fnss_pkg::fnss_cmd_t      cmd
);

  import fnss_pkg::*;

  fnss_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_UPDATE;
      S_UPDATE: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_UPDATE: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_capture_to_update: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_UPDATE))
    else $error("capture did not lead to update");
  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == S_IDLE))
    else $error("commit did not return to idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/fnss_dp.sv
// ----------------------------------------------------------------------------
// fnss_dp
// Datapath: config registers, node table, update logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnss_dp #(
  parameter int MAX_NODES = fnss_pkg::DEFAULT_MAX_NODES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [fnss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fnss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [fnss_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [fnss_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  wire fnss_pkg::fnss_cmd_t                 cmd,
  output fnss_pkg::fnss_sts_t                      sts
);

  import fnss_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [DELAY_W-1:0] recovery_delay;
  logic [COUNT_W-1:0] preop_stuck_limit;
  logic [COUNT_W-1:0] safeop_stuck_limit;

  logic [NODE_W-1:0]  node_q;
  logic [STATE_W-1:0] st_q;
  logic               in_range_q;
  logic               valid_q;
  logic [MAX_NODES-1:0] valid;

  logic [NODE_W-1:0]  s_node;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;
  logic [$bits(fnss_entry_t)-1:0] rdata;
  fnss_entry_t        entry_rd;
  fnss_entry_t        e;
  logic               req;
  logic               recovered;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_delay     <= RECOVERY_DELAY_RST;
      preop_stuck_limit  <= PREOP_LIMIT_RST;
      safeop_stuck_limit <= SAFEOP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECOVERY_DELAY: recovery_delay     <= cfg_wdata[DELAY_W-1:0];
        REG_PREOP_LIMIT:    preop_stuck_limit  <= cfg_wdata[COUNT_W-1:0];
        REG_SAFEOP_LIMIT:   safeop_stuck_limit <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_node = s_tdata[NODE_W-1:0];
  assign raddr  = AW'(s_node);
  assign waddr  = AW'(node_q);
  assign we     = cmd.commit && in_range_q;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_q     <= s_node;
      st_q       <= s_tdata[NODE_W +: STATE_W];
      in_range_q <= (32'(s_node) < MAX_NODES);
      valid_q    <= (32'(s_node) < MAX_NODES) ? valid[raddr] : 1'b0;
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  fnss_ram #(
    .WIDTH ($bits(fnss_entry_t)),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (e),
    .re    (cmd.capture),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign entry_rd = valid_q ? fnss_entry_t'(rdata) : '0;

  // per-node update
  always_comb begin
    e         = entry_rd;
    req       = 1'b0;
    recovered = 1'b0;
    if (st_q == ST_OP) begin
      if (e.lost) begin
        e.lost    = 1'b0;
        e.rec     = sat_inc(e.rec);
        recovered = 1'b1;
      end
      e.prev = st_q;
    end else begin
      if (st_q != e.prev) begin
        if (st_q == ST_INIT && e.err != '0) begin
          e.lost = 1'b1;
        end
        e.prev = st_q;
        e.err  = sat_inc(e.err);
      end
      if (st_q == ST_INIT || st_q == ST_NONE) begin
        if (!e.lost) begin
          e.lost = 1'b1;
          e.dly  = recovery_delay;
        end
      end else if (st_q == ST_PREOP) begin
        req = (e.err > preop_stuck_limit);
      end else if (st_q == ST_SAFEOP) begin
        req = (e.err > safeop_stuck_limit);
      end
      if (e.lost) begin
        if (e.dly != '0) begin
          e.dly = e.dly - 8'd1;
        end else begin
          req   = 1'b1;
          e.dly = recovery_delay;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (in_range_q) begin
        m_tdata <= {e.rec, e.err, recovered, e.lost, req, node_q};
      end else begin
        m_tdata <= {{(OUT_TDATA_W-NODE_W){1'b0}}, node_q};
      end
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;

`ifndef ASSERT_OFF
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");
  a_entry_marked: assert property (@(posedge clk) disable iff (rst)
    we |=> valid[$past(waddr)])
    else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

>>> rtl/fieldbus_node_state_supervisor.sv
// ----------------------------------------------------------------------------
// fieldbus_node_state_supervisor
// Tracks per-node application states from poll results and flags recovery.
// ----------------------------------------------------------------------------
// Each poll result is handled in order: first the node's table entry is read from
// the RAM (registered read), then it is updated and written back while the
// result is loaded into the output register. A new poll result is taken as
// soon as the previous one is committed, even if its result has not been
// taken yet; the update waits only while the output register is full and not taken.
// The table is cleared at reset through per-entry valid bits, so there is no
// clearing pass and the block is ready in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module fieldbus_node_state_supervisor #(
  parameter int MAX_NODES = fnss_pkg::DEFAULT_MAX_NODES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fnss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fnss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // node_index[4:0], reported_state[9:5], zero fill
  input  wire logic [fnss_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // result_node[4:0], request_operational[5], node_lost[6],
  // just_recovered[7], errors_seen[23:8], recoveries_seen[39:24]
  output logic      [fnss_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import fnss_pkg::*;

  fnss_cmd_t cmd;
  fnss_sts_t sts;

  fnss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fnss_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
